// File: rtl/core/iss_pkg.sv
// Shared types and codes for the indexed sequence store.
`timescale 1ns / 1ps
`default_nettype none

package iss_pkg;

  typedef enum logic [2:0] {
    OP_INIT    = 3'd0,
    OP_GET     = 3'd1,
    OP_INSERT  = 3'd2,
    OP_DELETE  = 3'd3,
    OP_ASSIGN  = 3'd4,
    OP_FIND    = 3'd5,
    OP_REVERSE = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_RD2,
    S_WR,
    S_SWAP,
    S_PUT,
    S_DONE
  } state_e;

  localparam int unsigned POS_W  = 5;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_OW = 5;

endpackage

`default_nettype wire

// File: rtl/core/iss_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
`timescale 1ns / 1ps
`default_nettype none

module iss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/indexed_sequence_store.sv
// Top level of the indexed sequence store: sequencer, cell RAM and result register.
`timescale 1ns / 1ps
`default_nettype none

// Bounded ordered list of CAPACITY words of DATA_WIDTH bits, held in one RAM with a
// live count. Each request carries an opcode (init, get, insert, delete, assign,
// find, reverse) and gives exactly one result: the word read by get, the found flag,
// the count afterwards, an empty flag and a status (ok, index out of range, full).
// Rejected requests leave the store untouched. A request is taken only while the
// sequencer is idle; it then walks the RAM one access at a time, since the RAM has
// one read and one write port and a registered read. The output register lets a
// new request in while the previous result is still waiting on out_ready_i. Cells
// have no reset; only live cells are ever read.

module indexed_sequence_store #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [2:0]                  opcode_i,
  input  wire logic [iss_pkg::POS_W-1:0]   position_i,
  input  wire logic [iss_pkg::WORD_W-1:0]  word_in_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [iss_pkg::WORD_W-1:0]  word_out_o,
  output logic                             found_o,
  output logic      [iss_pkg::CNT_OW-1:0]  count_o,
  output logic                             is_empty_o,
  output logic      [1:0]                  status_o
);

  import iss_pkg::*;

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  // compare width wide enough for both the position field and the live count
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

  // control
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               out_valid_q, out_valid_d;

  // request and working registers
  op_e                op_q, op_d;
  logic [CNT_W-1:0]   pos_q, pos_d;
  logic [DATA_WIDTH-1:0] word_q, word_d;
  logic [CNT_W-1:0]   idx_q, idx_d;   // walking index (low end for reverse)
  logic [CNT_W-1:0]   hi_q, hi_d;     // high end for reverse
  logic [DATA_WIDTH-1:0] tmp_q, tmp_d;

  // result being built
  logic [DATA_WIDTH-1:0] res_word_q, res_word_d;
  logic               found_q, found_d;
  status_e            status_q, status_d;

  // output register
  logic [WORD_W-1:0]  out_word_q, out_word_d;
  logic               out_found_q, out_found_d;
  logic [CNT_OW-1:0]  out_count_q, out_count_d;
  logic               out_empty_q, out_empty_d;
  logic [1:0]         out_status_q, out_status_d;

  // RAM port
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic [CMP_W-1:0] pos_c, cnt_c;

  assign pos_c = CMP_W'(position_i);
  assign cnt_c = CMP_W'(count_q);

  iss_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    op_d         = op_q;
    pos_d        = pos_q;
    word_d       = word_q;
    idx_d        = idx_q;
    hi_d         = hi_q;
    tmp_d        = tmp_q;
    res_word_d   = res_word_q;
    found_d      = found_q;
    status_d     = status_q;
    out_word_d   = out_word_q;
    out_found_d  = out_found_q;
    out_count_d  = out_count_q;
    out_empty_d  = out_empty_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q[AW-1:0];
    ram_wdata    = ram_rdata;
    ram_raddr    = idx_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d       = op_e'(opcode_i);
          pos_d      = CNT_W'(position_i);
          word_d     = DATA_WIDTH'(word_in_i);
          res_word_d = '0;
          found_d    = 1'b0;
          status_d   = ST_OK;
          state_d    = S_DONE;
          idx_d      = CNT_W'(position_i);
          case (opcode_i)
            OP_INIT: begin
              if (pos_c > CAP_C) begin
                status_d = ST_FULL;
              end else begin
                count_d = CNT_W'(position_i);
                idx_d   = '0;
                if (pos_c != '0) begin
                  state_d = S_PUT;
                end
              end
            end
            OP_GET: begin
              if (pos_c >= cnt_c) status_d = ST_RANGE;
              else                state_d  = S_RD;
            end
            OP_INSERT: begin
              if (pos_c > cnt_c) begin
                status_d = ST_RANGE;
              end else if (cnt_c == CAP_C) begin
                status_d = ST_FULL;
              end else begin
                // shift the tail up, starting from the end
                idx_d   = count_q;
                state_d = (pos_c == cnt_c) ? S_PUT : S_RD;
              end
            end
            OP_DELETE: begin
              if (pos_c >= cnt_c) begin
                status_d = ST_RANGE;
              end else if (pos_c + CMP_W'(1) == cnt_c) begin
                count_d = count_q - CNT_W'(1);   // last element: nothing to shift
              end else begin
                state_d = S_RD;
              end
            end
            OP_ASSIGN: begin
              if (pos_c >= cnt_c) status_d = ST_RANGE;
              else                state_d  = S_PUT;
            end
            OP_FIND: begin
              if (count_q != '0) begin
                idx_d   = '0;
                state_d = S_RD;
              end
            end
            OP_REVERSE: begin
              if (count_q > CNT_W'(1)) begin
                idx_d   = '0;
                hi_d    = count_q - CNT_W'(1);
                state_d = S_RD;
              end
            end
            default: ;   // spare code: no operation
          endcase
        end
      end

      S_RD: begin
        case (op_q)
          OP_INSERT: ram_raddr = AW'(idx_q - CNT_W'(1));
          OP_DELETE: ram_raddr = AW'(idx_q + CNT_W'(1));
          default:   ram_raddr = idx_q[AW-1:0];
        endcase
        state_d = (op_q == OP_REVERSE) ? S_RD2 : S_WR;
      end

      S_RD2: begin
        // low word arrives; fetch the high one
        tmp_d     = ram_rdata;
        ram_raddr = hi_q[AW-1:0];
        state_d   = S_WR;
      end

      S_WR: begin
        case (op_q)
          OP_GET: begin
            res_word_d = ram_rdata;
            state_d    = S_DONE;
          end
          OP_INSERT: begin
            ram_we  = 1'b1;
            idx_d   = idx_q - CNT_W'(1);
            state_d = (CNT_W'(idx_q - CNT_W'(1)) == pos_q) ? S_PUT : S_RD;
          end
          OP_DELETE: begin
            ram_we = 1'b1;
            idx_d  = idx_q + CNT_W'(1);
            if ((CNT_W+1)'(idx_q) + (CNT_W+1)'(2) >= (CNT_W+1)'(count_q)) begin
              count_d = count_q - CNT_W'(1);
              state_d = S_DONE;
            end else begin
              state_d = S_RD;
            end
          end
          OP_FIND: begin
            if (ram_rdata == word_q) begin
              found_d = 1'b1;
              state_d = S_DONE;
            end else if (CNT_W'(idx_q + CNT_W'(1)) == count_q) begin
              state_d = S_DONE;
            end else begin
              idx_d   = idx_q + CNT_W'(1);
              state_d = S_RD;
            end
          end
          OP_REVERSE: begin
            ram_we  = 1'b1;   // high word into the low slot
            state_d = S_SWAP;
          end
          default: state_d = S_DONE;
        endcase
      end

      S_SWAP: begin
        ram_we    = 1'b1;
        ram_waddr = hi_q[AW-1:0];
        ram_wdata = tmp_q;
        idx_d     = idx_q + CNT_W'(1);
        hi_d      = hi_q - CNT_W'(1);
        if ((CNT_W+1)'(idx_q) + (CNT_W+1)'(2) < (CNT_W+1)'(hi_q)) state_d = S_RD;
        else                                                        state_d = S_DONE;
      end

      S_PUT: begin
        ram_we    = 1'b1;
        ram_wdata = (op_q == OP_INIT) ? '0 : word_q;
        if (op_q == OP_INIT && CNT_W'(idx_q + CNT_W'(1)) != count_q) begin
          idx_d = idx_q + CNT_W'(1);
        end else begin
          if (op_q == OP_INSERT) begin
            count_d = count_q + CNT_W'(1);
          end
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_word_d   = WORD_W'(res_word_q);
          out_found_d  = found_q;
          out_count_d  = CNT_OW'(count_q);
          out_empty_d  = (count_q == '0);
          out_status_d = status_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    pos_q        <= pos_d;
    word_q       <= word_d;
    idx_q        <= idx_d;
    hi_q         <= hi_d;
    tmp_q        <= tmp_d;
    res_word_q   <= res_word_d;
    found_q      <= found_d;
    status_q     <= status_d;
    out_word_q   <= out_word_d;
    out_found_q  <= out_found_d;
    out_count_q  <= out_count_d;
    out_empty_q  <= out_empty_d;
    out_status_q <= out_status_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign word_out_o  = out_word_q;
  assign found_o     = out_found_q;
  assign count_o     = out_count_q;
  assign is_empty_o  = out_empty_q;
  assign status_o    = out_status_q;

endmodule

`default_nettype wire

// File: sim/indexed_sequence_store_tb.sv
// Self-checking testbench for the indexed sequence store: directed and random requests.
`timescale 1ns / 1ps

module indexed_sequence_store_tb;
  import iss_pkg::*;

  localparam int unsigned CAPACITY = 16;
  // Opcode seven has no package name; it must behave as a no-op.
  localparam logic [2:0] OP_UNUSED = 3'd7;

  // Everything one result carries, in the block's own widths.
  typedef struct {
    logic [WORD_W-1:0] word;
    logic              found;
    logic [CNT_OW-1:0] count;
    logic              is_empty;
    status_e           status;
  } outcome_t;

  // Scoreboard: mirrors the list contents and keeps the queue of outcomes
  // still owed by the block, oldest first.
  class list_scoreboard;
    logic [WORD_W-1:0] cells [CAPACITY];
    int unsigned       live_count = 0;
    outcome_t          pending_results [$];
    int unsigned       mismatches = 0;

    // Apply one accepted request to the mirror and queue its outcome.
    function void note_request(logic [2:0] op, logic [POS_W-1:0] pos, logic [WORD_W-1:0] word);
      outcome_t          res;
      logic [WORD_W-1:0] held;
      int unsigned       i;
      int unsigned       lo;
      int unsigned       hi;
      res.word   = '0;
      res.found  = 1'b0;
      res.status = ST_OK;
      case (op)
        OP_INIT: begin
          if (pos > CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            for (i = 0; i < pos; i++) cells[i] = '0;
            live_count = pos;
          end
        end
        OP_GET: begin
          if (pos >= live_count) res.status = ST_RANGE;
          else res.word = cells[pos];
        end
        OP_INSERT: begin
          // Range is checked before fullness.
          if (pos > live_count) begin
            res.status = ST_RANGE;
          end else if (live_count >= CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            for (i = live_count; i > pos; i--) cells[i] = cells[i-1];
            cells[pos] = word;
            live_count++;
          end
        end
        OP_DELETE: begin
          if (pos >= live_count) begin
            res.status = ST_RANGE;
          end else begin
            for (i = pos; i + 1 < live_count; i++) cells[i] = cells[i+1];
            live_count--;
          end
        end
        OP_ASSIGN: begin
          if (pos >= live_count) res.status = ST_RANGE;
          else cells[pos] = word;
        end
        OP_FIND: begin
          for (i = 0; i < live_count; i++) begin
            if (cells[i] == word) res.found = 1'b1;
          end
        end
        OP_REVERSE: begin
          if (live_count > 1) begin
            lo = 0;
            hi = live_count - 1;
            while (lo < hi) begin
              held      = cells[lo];
              cells[lo] = cells[hi];
              cells[hi] = held;
              lo++;
              hi--;
            end
          end
        end
        default: ;
      endcase
      res.count    = CNT_OW'(live_count);
      res.is_empty = (live_count == 0);
      pending_results.push_back(res);
    endfunction

    function void flag_field(string sig_name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      $display("%0t: %s mismatch, expected %h actual %h", $time, sig_name, want, got);
      mismatches++;
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual word %h count %0d",
                 $time, got.word, got.count);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.word !== want.word) flag_field("word_out", want.word, got.word);
      if (got.found !== want.found) flag_field("found", want.found, got.found);
      if (got.count !== want.count) flag_field("count", want.count, got.count);
      if (got.is_empty !== want.is_empty) flag_field("is_empty", want.is_empty, got.is_empty);
      if (got.status !== want.status) flag_field("status", want.status, got.status);
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [2:0]        opcode_i    = OP_INIT;
  logic [POS_W-1:0]  position_i  = '0;
  logic [WORD_W-1:0] word_in_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [WORD_W-1:0] word_out_o;
  logic              found_o;
  logic [CNT_OW-1:0] count_o;
  logic              is_empty_o;
  logic [1:0]        status_o;

  // Idle rates in percent, changed between phases.
  int unsigned send_gap_pct   = 11;
  int unsigned recv_stall_pct = 69;

  list_scoreboard sb;

  indexed_sequence_store #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (WORD_W)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .position_i  (position_i),
    .word_in_i   (word_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .word_out_o  (word_out_o),
    .found_o     (found_o),
    .count_o     (count_o),
    .is_empty_o  (is_empty_o),
    .status_o    (status_o)
  );

  always #5 clk_i = ~clk_i;

  // Result side: take a result when valid met ready on this edge (pre-edge
  // values), then pick next cycle's ready. Only one assignment to ready per edge.
  always @(posedge clk_i) begin
    outcome_t seen;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.word     = word_out_o;
      seen.found    = found_o;
      seen.count    = count_o;
      seen.is_empty = is_empty_o;
      seen.status   = status_e'(status_o);
      sb.check_result(seen);
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Present one request and hold it until accepted. A gap, if any, drops valid
  // on an earlier edge, so valid never gets two updates in one step.
  task automatic send_request(logic [2:0] op, logic [POS_W-1:0] pos, logic [WORD_W-1:0] word);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    position_i <= pos;
    word_in_i  <= word;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // Accepted on this edge: predict straight away so the next pick sees it.
    sb.note_request(op, pos, word);
  endtask

  // Stop sending until every owed result has been taken.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Random requests, mostly with indices in range; some words are taken from the live
  // part. The rest draw indices from a wider span that may go out of range.
  task automatic random_requests(int unsigned n_items);
    logic [2:0]        op;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
    int unsigned       pick;
    int unsigned       n;
    int unsigned       top;
    repeat (n_items) begin
      n    = sb.live_count;
      pick = $urandom_range(99);
      if (pick < 26)      op = OP_INSERT;
      else if (pick < 44) op = OP_DELETE;
      else if (pick < 59) op = OP_GET;
      else if (pick < 71) op = OP_ASSIGN;
      else if (pick < 86) op = OP_FIND;
      else if (pick < 94) op = OP_REVERSE;
      else if (pick < 99) op = OP_INIT;
      else                op = OP_UNUSED;

      if (op == OP_INIT) begin
        if ($urandom_range(19) == 0) pos = POS_W'($urandom_range(31, CAPACITY + 1));
        else pos = POS_W'($urandom_range(CAPACITY));
      end else if ($urandom_range(99) < 85) begin
        top = (op == OP_INSERT) ? n : ((n == 0) ? 0 : n - 1);
        pos = POS_W'($urandom_range(top));
      end else begin
        pos = POS_W'($urandom_range(($urandom_range(9) == 0) ? 31 : CAPACITY));
      end

      case ($urandom_range(9))
        0:       word = '0;
        1:       word = '1;
        2, 3, 4: word = (n != 0) ? sb.cells[$urandom_range(n - 1)] : WORD_W'($urandom());
        default: word = WORD_W'($urandom());
      endcase
      send_request(op, pos, word);
    end
  endtask

  initial begin
    sb = new;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase one: sender rarely idle, receiver mostly stalled.
    send_gap_pct   = 11;
    recv_stall_pct = 69;

    // Directed: empty-store corners first.
    send_request(OP_FIND,    5'd0,  32'h0000_0000);  // find on empty
    send_request(OP_REVERSE, 5'd0,  32'h0000_0000);  // reverse on empty
    send_request(OP_GET,     5'd0,  32'h0000_0000);  // get out of range
    send_request(OP_DELETE,  5'd0,  32'h0000_0000);  // delete out of range
    send_request(OP_ASSIGN,  5'd0,  32'hFFFF_FFFF);  // assign out of range
    send_request(OP_INSERT,  5'd1,  32'h1234_5678);  // insert past the end
    send_request(OP_INIT,    5'd17, 32'h0000_0000);  // init beyond capacity
    send_request(OP_INIT,    5'd31, 32'hFFFF_FFFF);
    send_request(OP_INIT,    5'd0,  32'h0000_0000);  // plain clear
    send_request(OP_INIT,    5'd16, 32'h0000_0000);  // fill with zeros
    send_request(OP_INSERT,  5'd16, 32'hDEAD_BEEF);  // full
    send_request(OP_INSERT,  5'd17, 32'hDEAD_BEEF);  // range wins over full
    send_request(OP_GET,     5'd15, 32'h0000_0000);
    send_request(OP_ASSIGN,  5'd15, 32'hFFFF_FFFF);
    send_request(OP_ASSIGN,  5'd0,  32'hAAAA_AAAA);
    send_request(OP_FIND,    5'd0,  32'hFFFF_FFFF);
    send_request(OP_REVERSE, 5'd0,  32'h0000_0000);
    send_request(OP_GET,     5'd0,  32'h0000_0000);
    send_request(OP_GET,     5'd16, 32'h0000_0000);
    send_request(OP_DELETE,  5'd15, 32'h0000_0000);  // delete the last
    send_request(OP_DELETE,  5'd0,  32'h0000_0000);  // delete the first
    send_request(OP_INSERT,  5'd0,  32'h5555_5555);  // insert at the head
    send_request(OP_INSERT,  5'd15, 32'h0000_0001);  // append at the count
    send_request(OP_UNUSED,  5'd31, 32'hFFFF_FFFF);  // no-op opcode
    send_request(OP_FIND,    5'd0,  32'h8000_0000);  // miss on a full store

    random_requests(360);
    hold_until_drained();

    // Phase two: the other way round.
    send_gap_pct   = 69;
    recv_stall_pct = 11;
    random_requests(380);
    hold_until_drained();

    // Phase three: back to back on both sides.
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    random_requests(385);
    hold_until_drained();

    // Wait out the longest operation, then catch any stray result.
    repeat (50) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #6_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
